@@ design/rdc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the radix digit converter: field widths, ASCII constants,
// transaction structs and the back end state type. No dependencies.
package rdc_pkg;

    localparam int VALUE_W         = 64;  // width of the value field
    localparam int RADIX_W         = 6;   // width of the radix field
    localparam int DIGIT_W         = 6;   // width of one digit value
    localparam int CHAR_W          = 7;   // width of one ASCII code
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_RADIX_DEF   = 36;
    localparam int MIN_RADIX       = 2;
    localparam int DEC_LIMIT       = 10;
    localparam int CHAR_ZERO       = 48;  // '0'
    localparam int CHAR_ALPHA      = 55;  // 'A' - 10

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_in;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_value;
        logic [CHAR_W-1:0]  digit_char;
        logic               last_digit;
    } t_out;

    // Classified job handed from front to back (radix already clamped).
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } t_back_state;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(DEC_LIMIT)) begin
            return dx + CHAR_W'(CHAR_ZERO);
        end else begin
            return dx + CHAR_W'(CHAR_ALPHA);
        end
    endfunction

endpackage

@@ design/rdc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input transactions, clamps the radix and holds the
// jobs in a two-entry queue for the back end. Depends on rdc_pkg.
module rdc_front #(
    parameter int MAX_RADIX = rdc_pkg::MAX_RADIX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rdc_pkg::t_in  i_in_data,
    output logic          o_job_valid,
    input  logic          i_job_pop,
    output rdc_pkg::t_job o_job
);
    import rdc_pkg::*;

    t_job       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    // Clamp the base into MIN_RADIX..MAX_RADIX.
    always_comb begin
        w_job.value = i_in_data.value;
        if (i_in_data.radix < RADIX_W'(MIN_RADIX)) begin
            w_job.radix = RADIX_W'(MIN_RADIX);
        end else if (i_in_data.radix > RADIX_W'(MAX_RADIX)) begin
            w_job.radix = RADIX_W'(MAX_RADIX);
        end else begin
            w_job.radix = i_in_data.radix;
        end
    end

    assign o_in_stall  = (r_count == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_count != 2'd0);
    assign w_pop       = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

endmodule

@@ design/rdc_back.sv @@
`timescale 1ns / 1ps
// Back end: bit-serial division by the radix, digit store, and emission of
// the digits most significant first through an output register. Depends on rdc_pkg.
module rdc_back #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = rdc_pkg::MAX_RADIX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  rdc_pkg::t_job i_job,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rdc_pkg::t_out o_out_data
);
    import rdc_pkg::*;

    localparam int IDX_W = $clog2(VALUE_WIDTH);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [VALUE_WIDTH-1:0] r_quot;
    logic [VALUE_WIDTH-1:0] n_quot;
    logic [RADIX_W-1:0]   r_radix;
    logic [DIGIT_W-1:0]   r_rem;
    logic [DIGIT_W-1:0]   n_rem;
    logic [IDX_W-1:0]     r_bit;
    logic [IDX_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_idx;
    logic [DIGIT_W-1:0]   r_store [VALUE_WIDTH];
    logic [DIGIT_W-1:0]   r_rd_data;
    logic                 r_out_valid;
    t_out                 r_out_data;
    logic [DIGIT_W:0]     w_trial;
    logic [DIGIT_W:0]     w_diff;
    logic                 w_ge;
    logic                 w_last_bit;
    logic                 w_digit_done;
    logic                 w_out_free;
    logic                 w_load_out;

    // One restoring-division step per cycle.
    assign w_trial    = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_ge       = (w_trial >= {{(DIGIT_W+1-RADIX_W){1'b0}}, r_radix});
    assign w_diff     = w_trial - {{(DIGIT_W+1-RADIX_W){1'b0}}, r_radix};
    assign n_rem      = w_ge ? w_diff[DIGIT_W-1:0] : w_trial[DIGIT_W-1:0];
    assign n_quot     = {r_quot[VALUE_WIDTH-2:0], w_ge};
    assign w_last_bit = (r_bit == IDX_W'(VALUE_WIDTH - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        o_job_pop    = 1'b0;
        w_digit_done = 1'b0;
        w_load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_last_bit) begin
                    w_digit_done = 1'b1;
                    if (n_quot == '0) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = (r_idx == '0) ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_quot  <= i_job.value[VALUE_WIDTH-1:0];
            r_radix <= i_job.radix;
            r_rem   <= '0;
            r_bit   <= '0;
            r_cnt   <= '0;
        end else if (r_state == ST_DIV) begin
            r_quot <= n_quot;
            if (w_digit_done) begin
                r_rem <= '0;
                r_bit <= '0;
                r_cnt <= r_cnt + IDX_W'(1);
                r_idx <= r_cnt;
            end else begin
                r_rem <= n_rem;
                r_bit <= r_bit + IDX_W'(1);
            end
        end else if (w_load_out) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (w_load_out) begin
            r_out_data.digit_value <= r_rd_data;
            r_out_data.digit_char  <= ascii_of(r_rd_data);
            r_out_data.last_digit  <= (r_idx == '0);
        end
    end

    // Digit store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_digit_done) begin
            r_store[r_cnt] <= n_rem;
        end
        r_rd_data <= r_store[r_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |->
        (r_radix >= RADIX_W'(MIN_RADIX)) && (r_radix <= RADIX_W'(MAX_RADIX)))
        else $error("radix out of range during division");

    a_load_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_LOAD))
        else $error("output register loaded outside digit load");

endmodule

@@ design/radix_digit_converter_core.sv @@
`timescale 1ns / 1ps
// The divider produces one quotient bit per cycle; each digit takes a full
// pass over the value, then the digits are read back from the digit store.
// The back end takes a new transaction only once the last digit of the one
// before has been loaded into the output register.
// Reset: i_rst_n synchronous active low; empties the queue and idles the
// back end. The digit store is not cleared.
module radix_digit_converter_core #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = rdc_pkg::MAX_RADIX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rdc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rdc_pkg::t_out o_out_data
);
    import rdc_pkg::*;

    // Queue handoff between front and back.
    logic w_job_valid;
    logic w_job_pop;
    t_job w_job;

    // Front: accept transactions, clamp the radix, buffer up to two jobs.
    rdc_front #(
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop),
        .o_job       (w_job)
    );

    // Back: divide repeatedly, store remainders, emit digits most
    // significant first with the final digit flagged.
    rdc_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_job       (w_job),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
